>>> hw/rtl/tanh_neuron_backprop_unit_top_defines.svh
// Assertion macros for the tanh neuron backprop unit.
`ifndef TANH_NEURON_BACKPROP_UNIT_TOP_DEFINES_SVH
`define TANH_NEURON_BACKPROP_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TNB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tnb assertion failed (same cycle)");

// Next-cycle implication, sampled on i_clk, off during reset.
`define TNB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tnb assertion failed (next cycle)");

`endif

>>> hw/rtl/tnb_pkg.sv
// Types, constants and fixed-point helpers shared by the tanh neuron unit.
package tnb_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_W    = 12;
    localparam int ACC_W     = 40;
    localparam int OP_W      = 3;
    localparam int IDX_W     = 6;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 15;
    localparam int MA_W      = 29;
    localparam int MB_W      = 20;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 20;
    localparam int DERIV_W   = 19;
    localparam int MAG_W     = 14;
    localparam int X2_W      = 16;
    localparam int KSUM_W    = 18;
    localparam int ONE_Q     = 1 << FRAC_W;
    localparam int TANH_K    = 27 * ONE_Q;

    typedef logic signed [DATA_W-1:0]  t_data;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [MA_W-1:0]    t_mul_a;
    typedef logic signed [MB_W-1:0]    t_mul_b;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [DERIV_W-1:0] t_deriv;

    localparam t_data            DATA_ONE   = t_data'(ONE_Q);
    localparam t_deriv           DERIV_ONE  = t_deriv'(ONE_Q);
    localparam logic [MA_W-1:0]  TANH_LIMIT = MA_W'(3 * ONE_Q);

    localparam logic signed [63:0] D_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [63:0] D_LO = -D_HI - 64'sd1;
    localparam logic signed [63:0] A_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam logic signed [63:0] A_LO = -A_HI - 64'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 3'd0,
        OP_FWD   = 3'd1,
        OP_OGRAD = 3'd2,
        OP_HID   = 3'd3,
        OP_UPD   = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACT    = 2'd0,
        KIND_GRAD   = 2'd1,
        KIND_WEIGHT = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_LEARN_RATE = 1'b0,
        CFG_MOMENTUM   = 1'b1
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FWD_RD, ST_ACC, ST_RND, ST_TANH_X, ST_TANH_SQ, ST_TANH_NUM,
        ST_TANH_DIV, ST_DSQ, ST_DSET, ST_HID_M, ST_GRAD, ST_UPD_RD, ST_UPD_T,
        ST_UPD_C, ST_UPD_S, ST_UPD_W, ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    // Drop FRAC_W bits, round to nearest with ties away from zero.
    function automatic logic signed [63:0] round_q(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        r   = (mag + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    // Clamp to the data range.
    function automatic t_data sat_d(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > D_HI) ? D_HI : ((v < D_LO) ? D_LO : v);
        return t_data'(c);
    endfunction

endpackage

>>> hw/rtl/tnb_in_if.sv
// Input channel of the tanh neuron unit: handshake and item payload.
interface tnb_in_if;
    logic                             valid;
    logic                             ready;
    logic [tnb_pkg::OP_W-1:0]         op;
    logic [tnb_pkg::IDX_W-1:0]        index;
    logic signed [tnb_pkg::DATA_W-1:0] value_a;
    logic signed [tnb_pkg::DATA_W-1:0] value_b;
    logic                             last;

    modport source (output valid, output op, output index, output value_a,
                    output value_b, output last, input ready);
    modport sink   (input valid, input op, input index, input value_a,
                    input value_b, input last, output ready);
endinterface

>>> hw/rtl/tnb_out_if.sv
// Output channel of the tanh neuron unit: handshake and result payload.
interface tnb_out_if;
    logic                              valid;
    logic                              ready;
    logic [tnb_pkg::KIND_W-1:0]        kind;
    logic signed [tnb_pkg::DATA_W-1:0] result_value;
    logic signed [tnb_pkg::DATA_W-1:0] result_change;

    modport source (output valid, output kind, output result_value,
                    output result_change, input ready);
    modport sink   (input valid, input kind, input result_value,
                    input result_change, output ready);
endinterface

>>> hw/rtl/tanh_neuron_backprop_unit_top.sv
// Top level of the tanh neuron backprop unit: sequencer, shared multiplier, weight store.
// One item at a time. Load, ignored, non-last forward and non-last hidden ops give no result;
// output gradient, last hidden, update and last forward (32-step divider) ops move their
// result into the output register.
// Synchronous active-low reset clears sequencer, accumulator, activation, gradient and
// registers; the weight/change memory is not cleared.
`include "tanh_neuron_backprop_unit_top_defines.svh"
module tanh_neuron_backprop_unit_top #(
    parameter int NUM_INPUTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tnb_in_if.sink                     i_in,
    tnb_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [tnb_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(NUM_INPUTS);
    localparam int DW     = tnb_pkg::DATA_W;

    tnb_pkg::t_state   r_state, n_state;
    tnb_pkg::t_div_req div_req;
    tnb_pkg::t_div_rsp div_rsp;

    // Latched item
    logic [tnb_pkg::OP_W-1:0]  r_op;
    logic [tnb_pkg::IDX_W-1:0] r_idx;
    tnb_pkg::t_data            r_a;
    logic                      r_last;
    logic                      r_ok;

    // Neuron state and registers
    tnb_pkg::t_acc             r_acc;
    tnb_pkg::t_data            r_out_val;
    tnb_pkg::t_data            r_grad;
    tnb_pkg::t_deriv           r_deriv;
    logic [tnb_pkg::CFG_W-1:0] r_lr;
    logic [tnb_pkg::CFG_W-1:0] r_mom;

    // Working registers
    tnb_pkg::t_mul_a            r_x;
    logic                       r_neg;
    logic [tnb_pkg::MAG_W-1:0]  r_mag;
    logic [tnb_pkg::X2_W-1:0]   r_x2;
    tnb_pkg::t_data             r_w;
    tnb_pkg::t_data             r_c;
    tnb_pkg::t_data             r_t;
    tnb_pkg::t_prod             r_m1;
    tnb_pkg::t_data             r_nc;
    tnb_pkg::t_prod             r_prod;

    // Pending result and output register
    logic [tnb_pkg::KIND_W-1:0] r_pk;
    tnb_pkg::t_data             r_pv;
    tnb_pkg::t_data             r_pc;
    logic                       r_ov;
    logic [tnb_pkg::KIND_W-1:0] r_okind;
    tnb_pkg::t_data             r_oval;
    tnb_pkg::t_data             r_ochg;

    // Combinational signals
    logic                       in_ready;
    logic                       in_acc;
    logic                       ok_in;
    logic                       slot_free;
    tnb_pkg::t_mul_a            mul_a;
    tnb_pkg::t_mul_b            mul_b;
    tnb_pkg::t_prod             w_prod;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [2*DW-1:0]            ram_wdata;
    logic [2*DW-1:0]            ram_rdata;
    tnb_pkg::t_data             rd_w;
    tnb_pkg::t_data             rd_c;
    tnb_pkg::t_acc              acc_sat;
    tnb_pkg::t_mul_a            rnd_x;
    logic [tnb_pkg::MA_W-1:0]   x_mag;
    logic                       x_big;
    logic [tnb_pkg::X2_W-1:0]   sq_x2;
    logic [tnb_pkg::KSUM_W-1:0] k_sum;
    logic [tnb_pkg::DIV_DEN_W-1:0] tanh_den;
    tnb_pkg::t_data             tanh_val;
    tnb_pkg::t_deriv            n_deriv;
    tnb_pkg::t_data             prod_rs;
    tnb_pkg::t_data             nc_sat;
    tnb_pkg::t_data             upd_w;
    logic signed [63:0]         acc_s64;
    logic signed [63:0]         q64;

    assign in_acc    = i_in.valid & in_ready;
    assign ok_in     = ({26'd0, i_in.index} < 32'(NUM_INPUTS));
    assign slot_free = !r_ov || o_out.ready;
    assign rd_w      = r_ok ? tnb_pkg::t_data'(ram_rdata[2*DW-1:DW]) : '0;
    assign rd_c      = r_ok ? tnb_pkg::t_data'(ram_rdata[DW-1:0]) : '0;

    // Weight and change store, one word per connection.
    tnb_ram #(
        .WIDTH (2 * DW),
        .DEPTH (NUM_INPUTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tnb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared multiplier, product registered every cycle.
    assign w_prod = tnb_pkg::t_prod'(mul_a) * tnb_pkg::t_prod'(mul_b);

    // Datapath arithmetic around the multiplier.
    always_comb begin
        acc_s64  = 64'(r_acc) + 64'(r_prod);
        acc_sat  = tnb_pkg::t_acc'((acc_s64 > tnb_pkg::A_HI) ? tnb_pkg::A_HI :
                   ((acc_s64 < tnb_pkg::A_LO) ? tnb_pkg::A_LO : acc_s64));
        rnd_x    = tnb_pkg::t_mul_a'(tnb_pkg::round_q(64'(r_acc)));
        x_mag    = r_x[tnb_pkg::MA_W-1] ? $unsigned(-r_x) : $unsigned(r_x);
        x_big    = (x_mag >= tnb_pkg::TANH_LIMIT);
        sq_x2    = r_prod[tnb_pkg::FRAC_W +: tnb_pkg::X2_W];
        k_sum    = tnb_pkg::KSUM_W'(tnb_pkg::TANH_K) + tnb_pkg::KSUM_W'(sq_x2);
        tanh_den = tnb_pkg::DIV_DEN_W'(tnb_pkg::TANH_K) + tnb_pkg::DIV_DEN_W'(r_x2)
                 + tnb_pkg::DIV_DEN_W'({r_x2, 3'b000});
        q64      = $signed(64'(div_rsp.quo));
        tanh_val = tnb_pkg::sat_d(r_neg ? -q64 : q64);
        n_deriv  = tnb_pkg::t_deriv'(64'(tnb_pkg::ONE_Q)
                 - (64'(r_prod) >>> tnb_pkg::FRAC_W));
        prod_rs  = tnb_pkg::sat_d(tnb_pkg::round_q(64'(r_prod)));
        nc_sat   = tnb_pkg::sat_d(tnb_pkg::round_q(64'(r_m1) + 64'(r_prod)));
        upd_w    = tnb_pkg::sat_d(64'(r_w) + 64'(r_nc));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tnb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (tnb_pkg::t_op'(i_in.op))
                        tnb_pkg::OP_FWD:   n_state = tnb_pkg::ST_FWD_RD;
                        tnb_pkg::OP_OGRAD: n_state = tnb_pkg::ST_GRAD;
                        tnb_pkg::OP_HID:   n_state = tnb_pkg::ST_ACC;
                        tnb_pkg::OP_UPD:   n_state = tnb_pkg::ST_UPD_RD;
                        default:           n_state = tnb_pkg::ST_IDLE;
                    endcase
                end
            end
            tnb_pkg::ST_FWD_RD:   n_state = tnb_pkg::ST_ACC;
            tnb_pkg::ST_ACC:      n_state = r_last ? tnb_pkg::ST_RND : tnb_pkg::ST_IDLE;
            tnb_pkg::ST_RND: begin
                n_state = (r_op == tnb_pkg::OP_FWD) ? tnb_pkg::ST_TANH_X : tnb_pkg::ST_HID_M;
            end
            tnb_pkg::ST_TANH_X:   n_state = x_big ? tnb_pkg::ST_DSQ : tnb_pkg::ST_TANH_SQ;
            tnb_pkg::ST_TANH_SQ:  n_state = tnb_pkg::ST_TANH_NUM;
            tnb_pkg::ST_TANH_NUM: n_state = tnb_pkg::ST_TANH_DIV;
            tnb_pkg::ST_TANH_DIV: n_state = div_rsp.done ? tnb_pkg::ST_DSQ : tnb_pkg::ST_TANH_DIV;
            tnb_pkg::ST_DSQ:      n_state = tnb_pkg::ST_DSET;
            tnb_pkg::ST_DSET:     n_state = tnb_pkg::ST_OUT;
            tnb_pkg::ST_HID_M:    n_state = tnb_pkg::ST_GRAD;
            tnb_pkg::ST_GRAD:     n_state = tnb_pkg::ST_OUT;
            tnb_pkg::ST_UPD_RD:   n_state = tnb_pkg::ST_UPD_T;
            tnb_pkg::ST_UPD_T:    n_state = tnb_pkg::ST_UPD_C;
            tnb_pkg::ST_UPD_C:    n_state = tnb_pkg::ST_UPD_S;
            tnb_pkg::ST_UPD_S:    n_state = tnb_pkg::ST_UPD_W;
            tnb_pkg::ST_UPD_W:    n_state = tnb_pkg::ST_OUT;
            tnb_pkg::ST_OUT:      n_state = slot_free ? tnb_pkg::ST_IDLE : tnb_pkg::ST_OUT;
            default:              n_state = tnb_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, store access, multiplier operands, divider start.
    always_comb begin
        in_ready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ADDR_W'(i_in.index);
        ram_wdata     = {i_in.value_a, i_in.value_b};
        ram_raddr     = ADDR_W'(i_in.index);
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = r_prod[tnb_pkg::DIV_NUM_W-1:0];
        div_req.den   = tanh_den;
        unique case (r_state)
            tnb_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                ram_we   = in_acc && ok_in && (i_in.op == tnb_pkg::OP_LOAD);
                if (i_in.op == tnb_pkg::OP_HID) begin
                    mul_a = tnb_pkg::t_mul_a'(i_in.value_a);
                    mul_b = tnb_pkg::t_mul_b'(i_in.value_b);
                end else begin
                    mul_a = tnb_pkg::t_mul_a'(64'(i_in.value_a) - 64'(r_out_val));
                    mul_b = tnb_pkg::t_mul_b'(r_deriv);
                end
            end
            tnb_pkg::ST_FWD_RD: begin
                mul_a = tnb_pkg::t_mul_a'(r_a);
                mul_b = tnb_pkg::t_mul_b'(rd_w);
            end
            tnb_pkg::ST_TANH_X: begin
                mul_a = tnb_pkg::t_mul_a'({1'b0, x_mag[tnb_pkg::MAG_W-1:0]});
                mul_b = tnb_pkg::t_mul_b'({1'b0, x_mag[tnb_pkg::MAG_W-1:0]});
            end
            tnb_pkg::ST_TANH_SQ: begin
                mul_a = tnb_pkg::t_mul_a'({1'b0, r_mag});
                mul_b = tnb_pkg::t_mul_b'({1'b0, k_sum});
            end
            tnb_pkg::ST_TANH_NUM: div_req.start = 1'b1;
            tnb_pkg::ST_DSQ: begin
                mul_a = tnb_pkg::t_mul_a'(r_out_val);
                mul_b = tnb_pkg::t_mul_b'(r_out_val);
            end
            tnb_pkg::ST_HID_M: begin
                mul_a = r_x;
                mul_b = tnb_pkg::t_mul_b'(r_deriv);
            end
            tnb_pkg::ST_UPD_RD: begin
                mul_a = tnb_pkg::t_mul_a'(r_a);
                mul_b = tnb_pkg::t_mul_b'(r_grad);
            end
            tnb_pkg::ST_UPD_T: begin
                mul_a = tnb_pkg::t_mul_a'(r_c);
                mul_b = tnb_pkg::t_mul_b'({1'b0, r_mom});
            end
            tnb_pkg::ST_UPD_C: begin
                mul_a = tnb_pkg::t_mul_a'(r_t);
                mul_b = tnb_pkg::t_mul_b'({1'b0, r_lr});
            end
            tnb_pkg::ST_UPD_W: begin
                ram_we    = r_ok;
                ram_waddr = ADDR_W'(r_idx);
                ram_wdata = {upd_w, r_nc};
            end
            default: begin
            end
        endcase
    end

    // Control state, neuron state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tnb_pkg::ST_IDLE;
            r_acc     <= '0;
            r_out_val <= '0;
            r_grad    <= '0;
            r_deriv   <= tnb_pkg::DERIV_ONE;
            r_lr      <= tnb_pkg::CFG_W'(614);
            r_mom     <= tnb_pkg::CFG_W'(2048);
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                tnb_pkg::ST_ACC:  r_acc <= acc_sat;
                tnb_pkg::ST_RND:  r_acc <= '0;
                tnb_pkg::ST_TANH_X: begin
                    if (x_big) begin
                        r_out_val <= r_x[tnb_pkg::MA_W-1] ? -tnb_pkg::DATA_ONE
                                                          : tnb_pkg::DATA_ONE;
                    end
                end
                tnb_pkg::ST_TANH_DIV: begin
                    if (div_rsp.done) begin
                        r_out_val <= tanh_val;
                    end
                end
                tnb_pkg::ST_DSET: r_deriv <= n_deriv;
                tnb_pkg::ST_GRAD: r_grad  <= prod_rs;
                default: begin
                end
            endcase
            // Load the output register, drop it once taken.
            if (r_state == tnb_pkg::ST_OUT && slot_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (tnb_pkg::t_cfg'(i_cfg_index))
                    tnb_pkg::CFG_LEARN_RATE: r_lr  <= i_cfg_data;
                    tnb_pkg::CFG_MOMENTUM:   r_mom <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            tnb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_op   <= i_in.op;
                    r_idx  <= i_in.index;
                    r_a    <= i_in.value_a;
                    r_last <= i_in.last;
                    r_ok   <= ok_in;
                end
            end
            tnb_pkg::ST_RND:     r_x <= rnd_x;
            tnb_pkg::ST_TANH_X: begin
                r_neg <= r_x[tnb_pkg::MA_W-1];
                r_mag <= x_mag[tnb_pkg::MAG_W-1:0];
            end
            tnb_pkg::ST_TANH_SQ: r_x2 <= sq_x2;
            tnb_pkg::ST_DSET: begin
                r_pk <= tnb_pkg::KIND_ACT;
                r_pv <= r_out_val;
                r_pc <= '0;
            end
            tnb_pkg::ST_GRAD: begin
                r_pk <= tnb_pkg::KIND_GRAD;
                r_pv <= prod_rs;
                r_pc <= '0;
            end
            tnb_pkg::ST_UPD_RD: begin
                r_w <= rd_w;
                r_c <= rd_c;
            end
            tnb_pkg::ST_UPD_T:   r_t  <= prod_rs;
            tnb_pkg::ST_UPD_C:   r_m1 <= r_prod;
            tnb_pkg::ST_UPD_S:   r_nc <= nc_sat;
            tnb_pkg::ST_UPD_W: begin
                r_pk <= tnb_pkg::KIND_WEIGHT;
                r_pv <= upd_w;
                r_pc <= r_nc;
            end
            default: begin
            end
        endcase
        if (r_state == tnb_pkg::ST_OUT && slot_free) begin
            r_okind <= r_pk;
            r_oval  <= r_pv;
            r_ochg  <= r_pc;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_ov;
    assign o_out.kind          = r_okind;
    assign o_out.result_value  = r_oval;
    assign o_out.result_change = r_ochg;

    // Store writes come only from a load transaction or the update write-back.
    `TNB_ASSERT_IMP(a_store_write_src, ram_we,
        (r_state == tnb_pkg::ST_UPD_W) || (r_state == tnb_pkg::ST_IDLE && in_acc))
    // A finished sum always leaves the accumulator cleared.
    `TNB_ASSERT_NEXT(a_acc_cleared, r_state == tnb_pkg::ST_RND, r_acc == '0)
    // The divider reports only while the sequencer waits for it.
    `TNB_ASSERT_IMP(a_div_done_wait, div_rsp.done, r_state == tnb_pkg::ST_TANH_DIV)
    // The derivative term never exceeds one.
    `TNB_ASSERT_IMP(a_deriv_max, r_state == tnb_pkg::ST_OUT, r_deriv <= tnb_pkg::DERIV_ONE)

endmodule

>>> hw/rtl/tnb_ram.sv
// Generic simple dual-port RAM with registered read.
module tnb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry and read one entry; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tnb_div.sv
// Restoring divider for the tanh quotient, one quotient bit per cycle.
module tnb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tnb_pkg::t_div_req i_req,
    output tnb_pkg::t_div_rsp o_rsp
);

    localparam int N_W   = tnb_pkg::DIV_NUM_W;
    localparam int D_W   = tnb_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(N_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [D_W:0]     trial;
    logic             fits;
    logic [D_W-1:0]   n_rem;

    // Shift in one dividend bit and try the subtract.
    always_comb begin
        trial = {r_rem, r_q[N_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
    end

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(N_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_q   <= {r_q[N_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule
